### sv/gpio_pkg.sv
// ----------------------------------------------------------------------------
// gpio_pkg: shared types and constants
// Register map indices, function codes, status codes, payload words.
// ----------------------------------------------------------------------------
package gpio_pkg;

	localparam int unsigned FIELDS_PER_FSEL = 10;
	localparam logic [5:0] FSEL_LAST = 6'd5;
	localparam logic [5:0] R_SET0 = 6'd7;
	localparam logic [5:0] R_SET1 = 6'd8;
	localparam logic [5:0] R_CLR0 = 6'd10;
	localparam logic [5:0] R_CLR1 = 6'd11;
	localparam logic [5:0] R_LEV0 = 6'd13;
	localparam logic [5:0] R_LEV1 = 6'd14;
	localparam logic [5:0] R_EDS0 = 6'd16;
	localparam logic [5:0] R_EDS1 = 6'd17;
	localparam logic [5:0] R_REN0 = 6'd19;
	localparam logic [5:0] R_REN1 = 6'd20;
	localparam logic [5:0] R_FEN0 = 6'd22;
	localparam logic [5:0] R_FEN1 = 6'd23;
	localparam logic [5:0] R_HEN0 = 6'd25;
	localparam logic [5:0] R_HEN1 = 6'd26;
	localparam logic [5:0] R_LEN0 = 6'd28;
	localparam logic [5:0] R_LEN1 = 6'd29;

	localparam logic [2:0] FN_INPUT  = 3'd0;
	localparam logic [2:0] FN_OUTPUT = 3'd1;
	localparam logic [2:0] FN_ALT5   = 3'd2;
	localparam logic [2:0] FN_ALT0   = 3'd4;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_DRIVE = 2'd2;
	localparam logic [1:0] REQ_UNDEF = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RO_WRITE = 3'd1;
	localparam logic [2:0] ST_WO_READ  = 3'd2;
	localparam logic [2:0] ST_BAD_PIN  = 3'd3;
	localparam logic [2:0] ST_BAD_FN   = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  reg_addr;
		logic [31:0] write_data;
		logic [5:0]  pin_index;
		logic        pin_level;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [2:0]  status;
		logic        irq_raise;
		logic [5:0]  irq_raise_pin;
		logic [31:0] irq_clear_mask;
		logic        bank_select;
		logic [31:0] notify_mask;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

### sv/gpio_ctrl.sv
// ----------------------------------------------------------------------------
// gpio_ctrl: sequencer
// Load a word, run it through the datapath, hold the result until taken.
// ----------------------------------------------------------------------------
module gpio_ctrl import gpio_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				// accept the next word as the result leaves
				if (!out_stall) begin
					in_stall = 1'b0;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### sv/gpio_dp.sv
// ----------------------------------------------------------------------------
// gpio_dp: register store and per-pin state
// Decode one request word and update pin vectors in parallel.
// ----------------------------------------------------------------------------
module gpio_dp import gpio_pkg::*; #(
	parameter int unsigned NUM_PINS = 54,
	parameter int unsigned NUM_REGS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	localparam int unsigned NB = 64;

	// plain register storage; LEV and EDS read from the pin vectors instead
	logic [31:0]   mem_q [NUM_REGS];
	logic [31:0]   mem_rd_q;
	logic [NB-1:0] written_q;
	logic [2:0]    fn_q [NUM_PINS];
	logic [NB-1:0] lvl_q, pend_q, ren_q, fen_q, hen_q, len_q;
	req_t req_q;
	rsp_t rsp_q;

	function automatic logic bank_of(input logic [5:0] r);
		bank_of = (r == R_SET1 || r == R_CLR1 || r == R_EDS1 || r == R_REN1 ||
			r == R_FEN1 || r == R_HEN1 || r == R_LEN1 || r == R_LEV1);
	endfunction

	function automatic logic [NB-1:0] place(input logic b, input logic [31:0] d);
		place = b ? {d, 32'd0} : {32'd0, d};
	endfunction

	function automatic logic [31:0] half(input logic b, input logic [NB-1:0] v);
		half = b ? v[63:32] : v[31:0];
	endfunction

	logic [NB-1:0] valid_mask;
	logic [NB-1:0][2:0] fn_pad;
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			valid_mask[i] = (i < NUM_PINS);
			fn_pad[i]     = (i < NUM_PINS) ? fn_q[i % NUM_PINS] : FN_INPUT;
		end
	end

	logic [5:0]    idx;
	logic [31:0]   data;
	logic          in_range, is_set, is_clr, is_eds, is_lev;
	logic [NB-1:0] out_pins, sel;
	logic [2:0]    pfn;
	logic          prev, lv, hit, bk, pin_ok, fn_ok, mem_we;
	logic [4:0]    bitpos;
	logic [NB-1:0] lvl_d, pend_d, ren_d, fen_d, hen_d, len_d;
	rsp_t          rsp_d;

	always_comb begin
		idx      = req_q.reg_addr;
		data     = req_q.write_data;
		in_range = ({26'd0, idx} < NUM_REGS);
		is_set   = (idx == R_SET0) || (idx == R_SET1);
		is_clr   = (idx == R_CLR0) || (idx == R_CLR1);
		is_eds   = (idx == R_EDS0) || (idx == R_EDS1);
		is_lev   = (idx == R_LEV0) || (idx == R_LEV1);
		bk       = bank_of(idx);
		sel      = place(bk, data) & valid_mask;
		for (int i = 0; i < NB; i++) out_pins[i] = valid_mask[i] && (fn_pad[i] == FN_OUTPUT);
		pfn      = fn_pad[req_q.pin_index];
		pin_ok   = ({26'd0, req_q.pin_index} < NUM_PINS);
		fn_ok    = (pfn == FN_INPUT) || (pfn == FN_ALT0) || (pfn == FN_ALT5);
		prev     = lvl_q[req_q.pin_index];
		lv       = req_q.pin_level;
		hit = (ren_q[req_q.pin_index] && !prev && lv) || (fen_q[req_q.pin_index] && prev && !lv)
			|| (len_q[req_q.pin_index] && !lv) || (hen_q[req_q.pin_index] && lv);
		bitpos   = req_q.pin_index[4:0];
		mem_we   = cmd.exec && (req_q.req_type == REQ_WRITE) && in_range && !is_lev;

		lvl_d  = lvl_q;
		pend_d = pend_q;
		ren_d  = ren_q;
		fen_d  = fen_q;
		hen_d  = hen_q;
		len_d  = len_q;
		rsp_d  = '0;
		case (req_q.req_type)
			REQ_READ: begin
				if (is_set || is_clr)
					rsp_d.status = ST_WO_READ;
				else if (is_lev)
					rsp_d.read_data = half(bk, lvl_q);
				else if (is_eds)
					rsp_d.read_data = half(bk, pend_q);
				else if (in_range && written_q[idx])
					rsp_d.read_data = mem_rd_q;
			end
			REQ_WRITE: begin
				if (is_lev) begin
					rsp_d.status = ST_RO_WRITE;
				end else if (in_range) begin
					if (is_set || is_clr) begin
						if (is_set) lvl_d = lvl_q | (sel & out_pins);
						else lvl_d = lvl_q & ~(sel & out_pins);
						rsp_d.bank_select = bk;
						rsp_d.notify_mask = half(bk, sel & out_pins);
					end else if (is_eds) begin
						pend_d = pend_q & ~sel;
						rsp_d.bank_select    = bk;
						rsp_d.irq_clear_mask = half(bk, sel & pend_q);
					end else if (idx == R_REN0 || idx == R_REN1) begin
						ren_d = (ren_q & ~place(bk, '1)) | place(bk, data);
					end else if (idx == R_FEN0 || idx == R_FEN1) begin
						fen_d = (fen_q & ~place(bk, '1)) | place(bk, data);
					end else if (idx == R_HEN0 || idx == R_HEN1) begin
						hen_d = (hen_q & ~place(bk, '1)) | place(bk, data);
					end else if (idx == R_LEN0 || idx == R_LEN1) begin
						len_d = (len_q & ~place(bk, '1)) | place(bk, data);
					end
				end
			end
			REQ_DRIVE: begin
				if (!pin_ok) begin
					rsp_d.status = ST_BAD_PIN;
				end else if (!fn_ok) begin
					rsp_d.status = ST_BAD_FN;
				end else begin
					lvl_d[req_q.pin_index] = lv;
					rsp_d.bank_select = req_q.pin_index[5];
					rsp_d.notify_mask = 32'd1 << bitpos;
					if (hit) begin
						pend_d[req_q.pin_index] = 1'b1;
						rsp_d.irq_raise     = 1'b1;
						rsp_d.irq_raise_pin = req_q.pin_index;
					end
				end
			end
			default: ;
		endcase
	end

	// request capture, store read at load, store write and result at execute
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req;
			mem_rd_q <= mem_q[req.reg_addr];
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
			if (mem_we) mem_q[idx] <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PINS; p++) fn_q[p] <= FN_INPUT;
			written_q <= '0;
			lvl_q <= '0; pend_q <= '0;
			ren_q <= '0; fen_q <= '0; hen_q <= '0; len_q <= '0;
		end else if (cmd.exec) begin
			lvl_q  <= lvl_d;
			pend_q <= pend_d;
			ren_q  <= ren_d;
			fen_q  <= fen_d;
			hen_q  <= hen_d;
			len_q  <= len_d;
			if (mem_we) written_q[idx] <= 1'b1;
			if (req_q.req_type == REQ_WRITE && in_range && idx <= FSEL_LAST) begin
				for (int p = 0; p < NUM_PINS; p++)
					if (idx == 6'(p / FIELDS_PER_FSEL))
						fn_q[p] <= data[(p % FIELDS_PER_FSEL)*3 +: 3];
			end
		end
	end

	assign rsp = rsp_q;

endmodule

### sv/gpio_controller_with_event_detect_unit.sv
// ----------------------------------------------------------------------------
// gpio_controller_with_event_detect_unit: GPIO block with event detection
// Register reads/writes and pin drives, one word at a time.
// ----------------------------------------------------------------------------
// A request word is captured at load, its result is registered in the
// execute state and held on out_data with out_valid in the done state
// until it is taken. No new word is accepted before that result is taken.
// A new word is accepted in the cycle its predecessor's result is taken.
// Reset clears pin functions, levels, enables, pending bits and the written
// flags of the register store, so every register reads as zero.
module gpio_controller_with_event_detect_unit import gpio_pkg::*; #(
	parameter int unsigned NUM_PINS = 54,
	parameter int unsigned NUM_REGS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	cmd_t cmd;

	// sequence each word through load and execute
	gpio_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd)
	);

	// hold all state and the result register
	gpio_dp #(.NUM_PINS(NUM_PINS), .NUM_REGS(NUM_REGS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .req(in_data), .rsp(out_data)
	);

endmodule

### sim/gpio_controller_with_event_detect_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_controller_with_event_detect_unit_test: self-checking bench
// Drives register reads, writes and pin drives through the valid/stall
// request channel, predicts every response word from a local model of the
// register store and pin state, and compares each field in order.
// ----------------------------------------------------------------------------
module gpio_controller_with_event_detect_unit_test;
	import gpio_pkg::*;

	localparam int unsigned PIN_COUNT = 54;
	localparam int unsigned REG_COUNT = 64;
	localparam int unsigned RANDOM_WORDS = 1400;

	localparam logic [3:0] EN_RISE = 4'd1;
	localparam logic [3:0] EN_FALL = 4'd2;
	localparam logic [3:0] EN_HIGH = 4'd4;
	localparam logic [3:0] EN_LOW  = 4'd8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;

	gpio_controller_with_event_detect_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block's state.
	logic [31:0] shadow_regs [REG_COUNT];
	logic [2:0]  shadow_fn [PIN_COUNT];
	logic        shadow_level [PIN_COUNT];
	logic [3:0]  shadow_en [PIN_COUNT];
	logic        shadow_pending [PIN_COUNT];

	rsp_t pending_rsp [$];
	int   fail_count = 0;
	bit   calm = 1'b0;	// true during the no-idle stretch

	function automatic void clear_shadow();
		for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
		for (int p = 0; p < PIN_COUNT; p++) begin
			shadow_fn[p] = FN_INPUT;
			shadow_level[p] = 1'b0;
			shadow_en[p] = '0;
			shadow_pending[p] = 1'b0;
		end
	endfunction

	function automatic void mirror_lev(int unsigned p, logic lv);
		shadow_regs[R_LEV0 + p / 32][p % 32] = lv;
	endfunction

	function automatic void load_enables(int unsigned bank, logic [31:0] d, logic [3:0] flag);
		for (int i = 0; i < 32; i++) begin
			int unsigned p;
			p = bank * 32 + i;
			if (p < PIN_COUNT) begin
				if (d[i]) shadow_en[p] |= flag;
				else shadow_en[p] &= ~flag;
			end
		end
	endfunction

	// Apply one request word to the shadow state and return its response.
	function automatic rsp_t gpio_respond(req_t rq);
		rsp_t r;
		logic [31:0] old;
		int unsigned p;
		logic lv, hit;
		logic [3:0] en;
		r = '0;
		case (rq.req_type)
			REQ_READ: begin
				if (rq.reg_addr inside {R_SET0, R_SET1, R_CLR0, R_CLR1})
					r.status = ST_WO_READ;
				else
					r.read_data = shadow_regs[rq.reg_addr];
			end
			REQ_WRITE: begin
				if (rq.reg_addr inside {R_LEV0, R_LEV1}) begin
					r.status = ST_RO_WRITE;
				end else begin
					old = shadow_regs[rq.reg_addr];
					shadow_regs[rq.reg_addr] = rq.write_data;
					if (rq.reg_addr <= FSEL_LAST) begin
						for (int i = 0; i < FIELDS_PER_FSEL; i++) begin
							p = rq.reg_addr * FIELDS_PER_FSEL + i;
							if (p < PIN_COUNT) shadow_fn[p] = rq.write_data[i*3 +: 3];
						end
					end else if (rq.reg_addr inside {R_SET0, R_SET1, R_CLR0, R_CLR1}) begin
						lv = rq.reg_addr inside {R_SET0, R_SET1};
						r.bank_select = rq.reg_addr inside {R_SET1, R_CLR1};
						for (int i = 0; i < 32; i++) begin
							p = r.bank_select * 32 + i;
							if (p < PIN_COUNT && rq.write_data[i] && shadow_fn[p] == FN_OUTPUT) begin
								shadow_level[p] = lv;
								mirror_lev(p, lv);
								r.notify_mask[i] = 1'b1;
							end
						end
						shadow_regs[rq.reg_addr] = '0;
					end else if (rq.reg_addr inside {R_EDS0, R_EDS1}) begin
						r.bank_select = (rq.reg_addr == R_EDS1);
						for (int i = 0; i < 32; i++) begin
							p = r.bank_select * 32 + i;
							if (p < PIN_COUNT && rq.write_data[i] && shadow_pending[p]) begin
								shadow_pending[p] = 1'b0;
								old[i] = 1'b0;
								r.irq_clear_mask[i] = 1'b1;
							end
						end
						shadow_regs[rq.reg_addr] = old;
					end else if (rq.reg_addr inside {R_REN0, R_REN1}) begin
						load_enables(32'(rq.reg_addr - R_REN0), rq.write_data, EN_RISE);
					end else if (rq.reg_addr inside {R_FEN0, R_FEN1}) begin
						load_enables(32'(rq.reg_addr - R_FEN0), rq.write_data, EN_FALL);
					end else if (rq.reg_addr inside {R_HEN0, R_HEN1}) begin
						load_enables(32'(rq.reg_addr - R_HEN0), rq.write_data, EN_HIGH);
					end else if (rq.reg_addr inside {R_LEN0, R_LEN1}) begin
						load_enables(32'(rq.reg_addr - R_LEN0), rq.write_data, EN_LOW);
					end
				end
			end
			REQ_DRIVE: begin
				p = 32'(rq.pin_index);
				if (p >= PIN_COUNT) begin
					r.status = ST_BAD_PIN;
				end else if (!(shadow_fn[p] inside {FN_INPUT, FN_ALT0, FN_ALT5})) begin
					r.status = ST_BAD_FN;
				end else begin
					en = shadow_en[p];
					lv = rq.pin_level;
					hit = ((en & EN_RISE) != 0 && !shadow_level[p] && lv) ||
						((en & EN_FALL) != 0 && shadow_level[p] && !lv) ||
						((en & EN_LOW) != 0 && !lv) || ((en & EN_HIGH) != 0 && lv);
					shadow_level[p] = lv;
					mirror_lev(p, lv);
					r.bank_select = rq.pin_index[5];
					r.notify_mask[p % 32] = 1'b1;
					if (hit) begin
						shadow_pending[p] = 1'b1;
						shadow_regs[R_EDS0 + p / 32][p % 32] = 1'b1;
						r.irq_raise = 1'b1;
						r.irq_raise_pin = rq.pin_index;
					end
				end
			end
			default: ;	// undefined request: all zero
		endcase
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 29);
	endfunction

	// Send one word; hold the payload until accepted.
	task automatic send_word(req_t rq);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= rq;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_rsp.push_back(gpio_respond(rq));
		if (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Receiver: stall at random, check every accepted response word.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, out_data);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h", $time,
						want.read_data, out_data.read_data);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_data.status);
					fail_count++;
				end
				if (out_data.irq_raise !== want.irq_raise) begin
					$display("%0t: irq_raise expected %b actual %b", $time,
						want.irq_raise, out_data.irq_raise);
					fail_count++;
				end
				if (out_data.irq_raise_pin !== want.irq_raise_pin) begin
					$display("%0t: irq_raise_pin expected %0d actual %0d", $time,
						want.irq_raise_pin, out_data.irq_raise_pin);
					fail_count++;
				end
				if (out_data.irq_clear_mask !== want.irq_clear_mask) begin
					$display("%0t: irq_clear_mask expected %h actual %h", $time,
						want.irq_clear_mask, out_data.irq_clear_mask);
					fail_count++;
				end
				if (out_data.bank_select !== want.bank_select) begin
					$display("%0t: bank_select expected %b actual %b", $time,
						want.bank_select, out_data.bank_select);
					fail_count++;
				end
				if (out_data.notify_mask !== want.notify_mask) begin
					$display("%0t: notify_mask expected %h actual %h", $time,
						want.notify_mask, out_data.notify_mask);
					fail_count++;
				end
			end
		end
		out_stall <= arst_n ? idle_now() : 1'b0;
	end

	// Directed table: request plus, where obvious, a typed-in response.
	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t rs;
	} row_t;

	function automatic req_t mk(logic [1:0] t, logic [5:0] idx, logic [31:0] d,
			logic [5:0] pin, logic lv);
		req_t q;
		q.req_type = t;
		q.reg_addr = idx;
		q.write_data = d;
		q.pin_index = pin;
		q.pin_level = lv;
		return q;
	endfunction

	function automatic rsp_t st_only(logic [2:0] s);
		rsp_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	// Random word weighted toward meaningful traffic.
	function automatic req_t random_word();
		req_t q;
		int unsigned pick;
		logic [5:0] hot [16] = '{R_SET0, R_SET1, R_CLR0, R_CLR1, R_LEV0, R_LEV1,
			R_EDS0, R_EDS1, R_REN0, R_REN1, R_FEN0, R_FEN1, R_HEN0, R_HEN1,
			R_LEN0, R_LEN1};
		q = '0;
		q.write_data = $urandom();
		q.pin_level = 1'($urandom_range(1));
		q.pin_index = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
			: 6'($urandom_range(53));
		q.reg_addr = 6'($urandom_range(63));
		pick = $urandom_range(99);
		if (pick < 40) begin
			q.req_type = REQ_DRIVE;
		end else if (pick < 75) begin
			q.req_type = REQ_WRITE;
			if ($urandom_range(2) == 0) begin
				q.reg_addr = 6'($urandom_range(5));
				// mostly input, output and alt5 fields
				for (int i = 0; i < 10; i++)
					if ($urandom_range(3) != 0)
						q.write_data[i*3 +: 3] = 3'($urandom_range(2));
			end else if ($urandom_range(3) != 0) begin
				q.reg_addr = hot[4'($urandom_range(15))];
			end
		end else if (pick < 97) begin
			q.req_type = REQ_READ;
			if ($urandom_range(1)) q.reg_addr = hot[4'($urandom_range(15))];
		end else begin
			q.req_type = REQ_UNDEF;
		end
		return q;
	endfunction

	initial begin
		row_t dir [$];
		row_t w;
		clear_shadow();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, write-only and read-only cases, undefined request, bad pins
		dir.push_back('{mk(REQ_READ, R_LEV0, '0, 0, 0), 1, '0});
		dir.push_back('{mk(REQ_READ, 6'd63, '0, 0, 0), 1, '0});
		dir.push_back('{mk(REQ_READ, R_SET0, '0, 0, 0), 1, st_only(ST_WO_READ)});
		dir.push_back('{mk(REQ_READ, R_CLR1, '0, 0, 0), 1, st_only(ST_WO_READ)});
		dir.push_back('{mk(REQ_WRITE, R_LEV1, '1, 0, 0), 1, st_only(ST_RO_WRITE)});
		dir.push_back('{mk(REQ_UNDEF, 6'd63, '1, 63, 1), 1, '0});
		dir.push_back('{mk(REQ_DRIVE, '0, '0, 6'd54, 1), 1, st_only(ST_BAD_PIN)});
		dir.push_back('{mk(REQ_DRIVE, '0, '0, 6'd63, 0), 1, st_only(ST_BAD_PIN)});
		// function select extremes, outputs on pins 0..9 and 50..53
		dir.push_back('{mk(REQ_WRITE, 6'd0, 32'h0924_9249, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, 6'd5, 32'hFFFF_F249, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_DRIVE, '0, '0, 6'd3, 1), 1, st_only(ST_BAD_FN)});
		dir.push_back('{mk(REQ_WRITE, R_SET0, '1, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_SET1, '1, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_CLR0, 32'h0000_0005, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_CLR1, '1, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_READ, R_LEV0, '0, 0, 0), 0, '0});
		// detect enables and events on input pins
		dir.push_back('{mk(REQ_WRITE, R_REN0, '1, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_FEN1, '1, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_HEN1, 32'h0000_0001, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_LEN0, 32'h8000_0000, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_DRIVE, '0, '0, 6'd31, 1), 0, '0});
		dir.push_back('{mk(REQ_DRIVE, '0, '0, 6'd32, 1), 0, '0});
		dir.push_back('{mk(REQ_DRIVE, '0, '0, 6'd32, 0), 0, '0});
		dir.push_back('{mk(REQ_READ, R_EDS0, '0, 0, 0), 0, '0});
		dir.push_back('{mk(REQ_WRITE, R_EDS0, '1, 0, 0), 0, '0});

		foreach (dir[i]) begin
			w = dir[i];
			if (w.typed) begin
				// check the typed row against the shadow before sending
				rsp_t probe;
				probe = gpio_respond(w.rq);
				clear_shadow();
				for (int k = 0; k < i; k++) void'(gpio_respond(dir[k].rq));
				if (probe !== w.rs) begin
					$display("%0t: table row %0d expected %h actual %h", $time, i,
						w.rs, probe);
					fail_count++;
				end
			end
			send_word(w.rq);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= 500 && n < 700);
			send_word(random_word());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
sv/gpio_pkg.sv
sv/gpio_ctrl.sv
sv/gpio_dp.sv
sv/gpio_controller_with_event_detect_unit.sv
sim/gpio_controller_with_event_detect_unit_test.sv
